@@ hdl/astq_pkg.sv @@
// ----------------------------------------------------------------------------
// astq_pkg
// Shared types, widths and codes for the affinity-sorted type queue block.
// ----------------------------------------------------------------------------
`default_nettype none
package astq_pkg;

   localparam int MaxTypesDef   = 16;
   localparam int QueueDepthDef = 64;

   localparam int KeyW    = 16;
   localparam int HandleW = 16;
   localparam int TimeW   = 24;
   localparam int RatioW  = 32;
   localparam int RankW   = 4;

   // status codes
   localparam logic [2:0] StPushed    = 3'd0;
   localparam logic [2:0] StPopped    = 3'd1;
   localparam logic [2:0] StEmpty     = 3'd2;
   localparam logic [2:0] StTableFull = 3'd3;
   localparam logic [2:0] StQueueFull = 3'd4;

   localparam logic ReqPush = 1'b0;
   localparam logic ReqPop  = 1'b1;

   localparam logic [1:0] KindCpu = 2'd0;
   localparam logic [1:0] KindGpu = 2'd1;

   // command broadcast from the sequencer to every cell
   typedef struct packed {
      logic             shift_en;   // cells above ins_pos take neighbour
      logic             write_en;   // cell at ins_pos takes the new entry
      logic [6:0]       ins_pos;
      logic [KeyW-1:0]  key;
      logic [RatioW-1:0] ratio;
   } cell_cmd_type;

endpackage : astq_pkg
`default_nettype wire

@@ hdl/astq_divider.sv @@
// ----------------------------------------------------------------------------
// astq_divider
// Restoring divider, one quotient bit a cycle, with saturation to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module astq_divider
   import astq_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  wire [TimeW-1:0]    cpu_max_us,
   input  wire [TimeW-1:0]    gpu_min_us,
   output logic               done,
   output logic [RatioW-1:0]  ratio
);
   localparam int NumW = TimeW + 16;   // 40-bit dividend
   localparam int DenW = TimeW + 1;

   logic [NumW-1:0]  num_ff, num_in;
   logic [DenW-1:0]  den_ff, den_in;
   logic [DenW-1:0]  rem_ff, rem_in;
   logic [NumW-1:0]  quo_ff, quo_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DenW:0]    trial;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[NumW-1]};
      if (start) begin
         num_in  = {cpu_max_us, 16'd0};
         den_in  = {1'b0, gpu_min_us} + DenW'(1);
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = 6'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NumW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DenW'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = trial[DenW-1:0];
            quo_in = {quo_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done  = done_ff;
   assign ratio = (|quo_ff[NumW-1:RatioW]) ? {RatioW{1'b1}} : quo_ff[RatioW-1:0];

endmodule : astq_divider
`default_nettype wire

@@ hdl/astq_rank_cell.sv @@
// ----------------------------------------------------------------------------
// astq_rank_cell
// One rank of the sorted type table: key, ratio and owned FIFO slot.
// ----------------------------------------------------------------------------
`default_nettype none
module astq_rank_cell
   import astq_pkg::*;
#(
   parameter int SlotW = 4
)(
   input  wire                clock,
   input  wire [6:0]          my_pos,
   input  cell_cmd_type       cmd,
   input  wire [SlotW-1:0]    new_slot,
   input  wire [KeyW-1:0]     prev_key,
   input  wire [RatioW-1:0]   prev_ratio,
   input  wire [SlotW-1:0]    prev_slot,
   output logic [KeyW-1:0]    key,
   output logic [RatioW-1:0]  ratio,
   output logic [SlotW-1:0]   slot
);
   logic [KeyW-1:0]   key_ff, key_in;
   logic [RatioW-1:0] ratio_ff, ratio_in;
   logic [SlotW-1:0]  slot_ff, slot_in;

   always_comb begin
      key_in   = key_ff;
      ratio_in = ratio_ff;
      slot_in  = slot_ff;
      if (cmd.write_en && my_pos == cmd.ins_pos) begin
         key_in   = cmd.key;
         ratio_in = cmd.ratio;
         slot_in  = new_slot;
      end else if (cmd.shift_en && my_pos > cmd.ins_pos) begin
         // entries above the insertion point move up by one rank
         key_in   = prev_key;
         ratio_in = prev_ratio;
         slot_in  = prev_slot;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      ratio_ff <= ratio_in;
      slot_ff  <= slot_in;
   end

   assign key   = key_ff;
   assign ratio = ratio_ff;
   assign slot  = slot_ff;

endmodule : astq_rank_cell
`default_nettype wire

@@ hdl/affinity_sorted_type_queues_unit.sv @@
// rsp_tvalid rises once a pop, a push to a known type or a rejected push is accepted and the
// scan, one rank per cycle, has reached its rank; a pop adds a memory read before the response.
// A new type passes through the scan, the divider, a walk down to the insertion rank and the
// shift into the table.
// One item at a time; the next is accepted in the cycle after the result is taken.
// Reset clears the type count, FIFO heads and fills and the control state; no clearing pass.
// ----------------------------------------------------------------------------
// affinity_sorted_type_queues_unit
// Sorted table of task types, each with its own handle FIFO, served by CPU/GPU pops.
// ----------------------------------------------------------------------------
`default_nettype none
module affinity_sorted_type_queues_unit
   import astq_pkg::*;
#(
   parameter int MAX_TYPES   = MaxTypesDef,
   parameter int QUEUE_DEPTH = QueueDepthDef
)(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // [0] req_type [16:1] type_key [32:17] task_handle [56:33] cpu_max_time
   // [80:57] gpu_min_time [82:81] worker_kind, zero to 88 bits
   input  wire  [87:0]  req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // [2:0] status [18:3] popped_handle [22:19] served_rank, zero to 24 bits
   output logic [23:0]  rsp_tdata
);
   localparam int SlotW = $clog2(MAX_TYPES);
   localparam int CntW  = $clog2(MAX_TYPES + 1);
   localparam int PtrW  = $clog2(QUEUE_DEPTH);
   localparam int FillW = $clog2(QUEUE_DEPTH + 1);
   localparam int MemD  = MAX_TYPES * QUEUE_DEPTH;
   localparam int AddrW = $clog2(MemD);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SCAN   = 7'b0000010,
      S_DIV    = 7'b0000100,
      S_FIND   = 7'b0001000,
      S_INSERT = 7'b0010000,
      S_READ   = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic             rq_type_ff;
   logic [KeyW-1:0]  rq_key_ff;
   logic [HandleW-1:0] rq_handle_ff;
   logic [TimeW-1:0] rq_cpu_ff, rq_gpu_ff;
   logic [1:0]       rq_kind_ff;

   logic [CntW-1:0]  type_count_ff, type_count_in;
   logic [PtrW-1:0]  head_ff [MAX_TYPES];
   logic [FillW-1:0] fill_ff [MAX_TYPES];
   logic [HandleW-1:0] mem [MemD];
   logic [HandleW-1:0] rd_data_ff;

   logic [CntW-1:0]  idx_ff, idx_in;
   logic [2:0]       st_ff, st_in;
   logic [RankW-1:0] rank_ff, rank_in;
   logic             rsp_valid_ff;

   // memory access this cycle
   logic             mem_we, mem_re;
   logic [AddrW-1:0] mem_addr;
   logic             head_inc, fill_inc, fill_dec, slot_init;
   logic [SlotW-1:0] op_slot;

   cell_cmd_type     cmd;
   logic             div_start, div_done;
   logic [RatioW-1:0] div_ratio;

   logic [KeyW-1:0]   c_key   [MAX_TYPES];
   logic [RatioW-1:0] c_ratio [MAX_TYPES];
   logic [SlotW-1:0]  c_slot  [MAX_TYPES];

   astq_divider u_div (
      .clock, .reset, .start(div_start), .cpu_max_us(rq_cpu_ff),
      .gpu_min_us(rq_gpu_ff), .done(div_done), .ratio(div_ratio)
   );

   genvar g;
   generate
      for (g = 0; g < MAX_TYPES; g++) begin : g_cell
         if (g == 0) begin : g_first
            astq_rank_cell #(.SlotW(SlotW)) u_cell (
               .clock, .my_pos(7'(g)), .cmd, .new_slot(SlotW'(type_count_ff)),
               .prev_key(c_key[g]), .prev_ratio(c_ratio[g]), .prev_slot(c_slot[g]),
               .key(c_key[g]), .ratio(c_ratio[g]), .slot(c_slot[g])
            );
         end else begin : g_rest
            astq_rank_cell #(.SlotW(SlotW)) u_cell (
               .clock, .my_pos(7'(g)), .cmd, .new_slot(SlotW'(type_count_ff)),
               .prev_key(c_key[g-1]), .prev_ratio(c_ratio[g-1]),
               .prev_slot(c_slot[g-1]),
               .key(c_key[g]), .ratio(c_ratio[g]), .slot(c_slot[g])
            );
         end
      end
   endgenerate

   logic [SlotW-1:0]  idx_s;
   logic [SlotW-1:0]  cur_slot;
   logic [PtrW:0]     wr_sum;
   logic [PtrW-1:0]   wr_ptr;
   logic              full_tab;

   assign idx_s    = idx_ff[SlotW-1:0];
   assign cur_slot = c_slot[idx_s];
   assign full_tab = (type_count_ff == CntW'(MAX_TYPES));

   always_comb begin
      state_in      = state_ff;
      type_count_in = type_count_ff;
      idx_in        = idx_ff;
      st_in         = st_ff;
      rank_in       = rank_ff;
      mem_we = 1'b0; mem_re = 1'b0;
      head_inc = 1'b0; fill_inc = 1'b0; fill_dec = 1'b0; slot_init = 1'b0;
      op_slot  = cur_slot;
      div_start = 1'b0;
      cmd = '0;
      cmd.key   = rq_key_ff;
      cmd.ratio = div_ratio;
      cmd.ins_pos = 7'(idx_ff);
      wr_sum = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_SCAN;
               rank_in  = '0;
               st_in    = StEmpty;
               idx_in   = (req_tdata[0] == ReqPop && req_tdata[82:81] == KindGpu)
                          ? CntW'(MAX_TYPES) : '0;
            end
         end
         S_SCAN: begin
            if (rq_type_ff == ReqPush) begin
               if (idx_ff == type_count_ff) begin
                  if (full_tab) begin
                     st_in = StTableFull;
                     state_in = S_RESP;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end else if (c_key[idx_s] == rq_key_ff) begin
                  rank_in = RankW'(idx_ff);
                  if (fill_ff[cur_slot] == FillW'(QUEUE_DEPTH)) begin
                     st_in = StQueueFull;
                  end else begin
                     st_in   = StPushed;
                     mem_we  = 1'b1;
                     fill_inc = 1'b1;
                  end
                  state_in = S_RESP;
               end else begin
                  idx_in = idx_ff + CntW'(1);
               end
            end else if (rq_kind_ff == KindCpu) begin
               if (idx_ff == type_count_ff) begin
                  state_in = S_RESP;
               end else if (fill_ff[cur_slot] != '0) begin
                  mem_re = 1'b1; head_inc = 1'b1; fill_dec = 1'b1;
                  st_in = StPopped; rank_in = RankW'(idx_ff);
                  state_in = S_READ;
               end else begin
                  idx_in = idx_ff + CntW'(1);
               end
            end else if (rq_kind_ff == KindGpu) begin
               if (idx_ff > type_count_ff) begin
                  idx_in = type_count_ff;
               end else if (idx_ff == '0) begin
                  state_in = S_RESP;
               end else begin
                  op_slot = c_slot[SlotW'(idx_ff - CntW'(1))];
                  if (fill_ff[op_slot] != '0) begin
                     mem_re = 1'b1; head_inc = 1'b1; fill_dec = 1'b1;
                     st_in = StPopped; rank_in = RankW'(idx_ff - CntW'(1));
                     state_in = S_READ;
                  end else begin
                     idx_in = idx_ff - CntW'(1);
                  end
               end
            end else begin
               state_in = S_RESP;
            end
         end
         S_DIV: begin
            if (div_done) begin
               idx_in   = type_count_ff;
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            // walk down from the top while the rank below holds a larger ratio
            if (idx_ff != '0 && c_ratio[SlotW'(idx_ff - CntW'(1))] > div_ratio) begin
               idx_in = idx_ff - CntW'(1);
            end else begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            cmd.shift_en = 1'b1;
            cmd.write_en = 1'b1;
            op_slot   = SlotW'(type_count_ff);
            slot_init = 1'b1;
            mem_we    = 1'b1;
            type_count_in = type_count_ff + CntW'(1);
            rank_in  = RankW'(idx_ff);
            st_in    = StPushed;
            state_in = S_RESP;
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_valid_ff && rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (slot_init) begin
         wr_ptr = '0;
      end else begin
         wr_sum = {1'b0, head_ff[op_slot]} + (PtrW+1)'(fill_ff[op_slot]);
         wr_ptr = (wr_sum >= (PtrW+1)'(QUEUE_DEPTH))
                  ? PtrW'(wr_sum - (PtrW+1)'(QUEUE_DEPTH)) : wr_sum[PtrW-1:0];
      end
      if (mem_re) mem_addr = AddrW'(op_slot) * AddrW'(QUEUE_DEPTH)
                             + AddrW'(head_ff[op_slot]);
      else        mem_addr = AddrW'(op_slot) * AddrW'(QUEUE_DEPTH) + AddrW'(wr_ptr);
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= rq_handle_ff;
      if (mem_re) rd_data_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         rq_type_ff   <= req_tdata[0];
         rq_key_ff    <= req_tdata[16:1];
         rq_handle_ff <= req_tdata[32:17];
         rq_cpu_ff    <= req_tdata[56:33];
         rq_gpu_ff    <= req_tdata[80:57];
         rq_kind_ff   <= req_tdata[82:81];
      end
      idx_ff  <= idx_in;
      st_ff   <= st_in;
      rank_ff <= rank_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         type_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_TYPES; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         type_count_ff <= type_count_in;
         if (state_in == S_RESP && state_ff != S_RESP) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready)          rsp_valid_ff <= 1'b0;
         if (slot_init) begin
            head_ff[op_slot] <= '0;
            fill_ff[op_slot] <= FillW'(1);
         end else begin
            if (head_inc) head_ff[op_slot] <= (head_ff[op_slot] == PtrW'(QUEUE_DEPTH - 1))
                                              ? '0 : head_ff[op_slot] + PtrW'(1);
            if (fill_inc) fill_ff[op_slot] <= fill_ff[op_slot] + FillW'(1);
            if (fill_dec) fill_ff[op_slot] <= fill_ff[op_slot] - FillW'(1);
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rank_ff, (st_ff == StPopped) ? rd_data_ff : HandleW'(0), st_ff};

   // a response is only raised while the sequencer sits in its response state
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> state_ff == S_RESP) else $error("response outside S_RESP");
   // the type count never exceeds the table size
   assert property (@(posedge clock) disable iff (reset)
      type_count_ff <= CntW'(MAX_TYPES)) else $error("type count overflow");
   // a new type is only inserted below a full table
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INSERT |-> !full_tab) else $error("insert into full table");

endmodule : affinity_sorted_type_queues_unit
`default_nettype wire

@@ dv/tb_affinity_sorted_type_queues_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_affinity_sorted_type_queues_unit
// Self-checking testbench: a behavioural scheduler model predicts the status,
// handle and rank of every item, and a checker compares each result in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_affinity_sorted_type_queues_unit
   import astq_pkg::*;
();

   localparam int NTypes = MaxTypesDef;
   localparam int Depth  = QueueDepthDef;
   localparam int WatchdogLimit = 20000;

   // Laid out as on rsp_tdata: rank on top, status in the lowest bits.
   typedef struct packed {
      logic [3:0]  rank;
      logic [15:0] handle;
      logic [2:0]  status;
   } sched_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   affinity_sorted_type_queues_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Scheduler state as predicted.
   int unsigned   type_total;
   logic [15:0]   ord_key   [NTypes];
   logic [31:0]   ord_ratio [NTypes];
   int unsigned   ord_slot  [NTypes];
   logic [15:0]   handle_q  [NTypes][$];

   sched_result_type pending_results[$];
   int unsigned   mismatch_count = 0;
   int unsigned   items_sent = 0;
   int unsigned   results_seen = 0;
   int unsigned   pops_served = 0;
   int unsigned   idle_cycles = 0;
   bit            hold_off = 1'b0;
   bit            fill_mode = 1'b0;

   function automatic logic [31:0] accel_ratio(logic [23:0] cpu, logic [23:0] gpu);
      logic [63:0] q;
      q = ({40'd0, cpu} << 16) / ({40'd0, gpu} + 64'd1);
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   function automatic sched_result_type schedule(logic req, logic [15:0] key,
                                                 logic [15:0] hnd,
                                                 logic [23:0] cpu, logic [23:0] gpu,
                                                 logic [1:0] kind);
      sched_result_type res;
      int r;
      logic [31:0] ratio;
      res = '{status: StEmpty, handle: 16'd0, rank: 4'd0};
      if (req == ReqPush) begin
         for (r = 0; r < type_total; r++)
            if (ord_key[r] == key) break;
         if (r < type_total) begin
            res.rank = r[3:0];
            if (handle_q[ord_slot[r]].size() >= Depth) res.status = StQueueFull;
            else begin
               handle_q[ord_slot[r]].push_back(hnd);
               res.status = StPushed;
            end
         end else if (type_total >= NTypes) begin
            res.status = StTableFull;
         end else begin
            ratio = accel_ratio(cpu, gpu);
            handle_q[type_total] = {hnd};
            r = type_total;
            while (r > 0 && ord_ratio[r-1] > ratio) begin
               ord_key[r] = ord_key[r-1];
               ord_ratio[r] = ord_ratio[r-1];
               ord_slot[r] = ord_slot[r-1];
               r--;
            end
            ord_key[r] = key;
            ord_ratio[r] = ratio;
            ord_slot[r] = type_total;
            type_total++;
            res.rank = r[3:0];
            res.status = StPushed;
         end
      end else if (kind == KindCpu) begin
         for (r = 0; r < type_total; r++)
            if (handle_q[ord_slot[r]].size() != 0) begin
               res.status = StPopped;
               res.handle = handle_q[ord_slot[r]].pop_front();
               res.rank = r[3:0];
               break;
            end
      end else if (kind == KindGpu) begin
         for (r = int'(type_total) - 1; r >= 0; r--)
            if (handle_q[ord_slot[r]].size() != 0) begin
               res.status = StPopped;
               res.handle = handle_q[ord_slot[r]].pop_front();
               res.rank = r[3:0];
               break;
            end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // Sends one item; the sender idles in bursts with random gaps. The valid stays
   // high after an accepted item so that the next item can follow without a gap.
   int unsigned burst_left = 0;
   task automatic send_item(logic req, logic [15:0] key, logic [15:0] hnd,
                            logic [23:0] cpu, logic [23:0] gpu, logic [1:0] kind);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      pending_results.push_back(schedule(req, key, hnd, cpu, gpu, kind));
      req_tdata <= {5'd0, kind, gpu, cpu, hnd, key, req};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic push_item(logic [15:0] key, logic [15:0] hnd, logic [23:0] cpu,
                            logic [23:0] gpu);
      send_item(ReqPush, key, hnd, cpu, gpu, 2'd0);
   endtask

   task automatic pop_item(logic [1:0] kind);
      send_item(ReqPop, 16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom), kind);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Receiver: own stall pattern, plus a long hold-off when asked.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_off) rsp_tready <= 1'b0;
      else if (fill_mode) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      sched_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[22:0];
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", got, 0);
         end else begin
            want = pending_results.pop_front();
            if (got.status != want.status) report_mismatch("status", got.status, want.status);
            if (got.handle != want.handle) report_mismatch("handle", got.handle, want.handle);
            if (got.rank != want.rank) report_mismatch("rank", got.rank, want.rank);
            if (want.status == StPopped) pops_served++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Watchdog expired with %0d results outstanding", pending_results.size());
         $display("** affinity_sorted_type_queues_unit: FAILED **");
         $finish;
      end
   end

   // Empty pops, other workers, extreme ratios, ties and the GPU end at rank 0.
   task automatic test_directed();
      pop_item(KindCpu);
      pop_item(KindGpu);
      push_item(16'h0000, 16'hFFFF, 24'hFFFFFF, 24'd0);      // saturated ratio
      push_item(16'hFFFF, 16'h0000, 24'd0, 24'hFFFFFF);      // zero ratio
      push_item(16'h1234, 16'hA5A5, 24'd100, 24'd99);        // exactly 1.0
      push_item(16'h4321, 16'h5A5A, 24'd100, 24'd99);        // tie goes after
      push_item(16'h0000, 16'h0001, 24'd5, 24'd5);           // known key
      pop_item(2'd2);
      pop_item(2'd3);
      pop_item(KindGpu);
      pop_item(KindGpu);
      pop_item(KindCpu);
      pop_item(KindCpu);
      pop_item(KindGpu);
      pop_item(KindGpu);
      pop_item(KindGpu);
      wait_drained();
   endtask

   // Fill the table, reject a new key, and overflow one FIFO.
   task automatic test_table_and_queue_full();
      int k;
      for (k = type_total; k < NTypes; k++)
         push_item(16'(16'h2000 + k), 16'($urandom), 24'($urandom),
                   24'($urandom_range(0, 50)));
      push_item(16'hBEEF, 16'h7777, 24'd1, 24'd1);
      fill_mode = 1'b1;
      for (k = 0; k < Depth + 2; k++) push_item(16'h1234, 16'($urandom), 24'd0, 24'd0);
      fill_mode = 1'b0;
      // Long receiver hold-off while the sender keeps offering items.
      hold_off = 1'b1;
      fork
         begin repeat (400) @(posedge clock); hold_off = 1'b0; end
         for (k = 0; k < 20; k++) pop_item(KindGpu);
      join
      for (k = 0; k < Depth + 20; k++) pop_item(2'($urandom_range(0, 1)));
      wait_drained();
   endtask

   // Random traffic; the design is reset only once, so the table stays full.
   task automatic test_random(int n);
      int k;
      logic [15:0] keys [NTypes];
      for (k = 0; k < NTypes; k++) keys[k] = (k < type_total) ? ord_key[k] : 16'h0;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: push_item(keys[$urandom_range(0, NTypes - 1)], 16'($urandom),
                                  24'($urandom), 24'($urandom));
            4: push_item(16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));
            default: pop_item(2'(($urandom_range(0, 9) == 0) ? $urandom_range(2, 3)
                                                             : $urandom_range(0, 1)));
         endcase
         if (k == n / 2) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      type_total = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_and_queue_full();
      test_random(400);
      repeat (200) @(posedge clock);
      $display("Sent %0d items, checked %0d results, %0d of them pops that returned a task.",
               items_sent, results_seen, pops_served);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("** affinity_sorted_type_queues_unit: PASSED **");
      end else begin
         $display("** affinity_sorted_type_queues_unit: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ filelist.f @@
hdl/astq_pkg.sv
hdl/astq_divider.sv
hdl/astq_rank_cell.sv
hdl/affinity_sorted_type_queues_unit.sv
dv/tb_affinity_sorted_type_queues_unit.sv
